// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk and off during reset
`define COAB_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, checked on clk and off during reset
`define COAB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// File: rtl/coab_pkg.sv
// types and constants of the cursor overlay blend unit
package coab_pkg;

	// request kinds carried in s_tuser
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_COMP = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_HOT_X   = 3'd2;
	localparam logic [2:0] REG_HOT_Y   = 3'd3;
	localparam logic [2:0] REG_SRC_W   = 3'd4;
	localparam logic [2:0] REG_SRC_H   = 3'd5;
	localparam logic [2:0] REG_ORIENT  = 3'd6;
	localparam logic [2:0] REG_VISIBLE = 3'd7;

	// output transforms
	localparam logic [2:0] ORI_NORMAL = 3'd0;
	localparam logic [2:0] ORI_R90    = 3'd1;
	localparam logic [2:0] ORI_R180   = 3'd2;
	localparam logic [2:0] ORI_R270   = 3'd3;
	localparam logic [2:0] ORI_FLIP   = 3'd4;
	localparam logic [2:0] ORI_F90    = 3'd5;
	localparam logic [2:0] ORI_F180   = 3'd6;
	localparam logic [2:0] ORI_F270   = 3'd7;

	// stream and configuration word widths
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 32;
	localparam int CFG_W    = 14;

	// blend arithmetic widths
	localparam int NUM_W  = 25;
	localparam int COMB_W = 17;
	localparam int QUO_W  = 8;

	// one rgba pixel, red in the low byte
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} pixel_t;

endpackage

// File: rtl/cursor_overlay_alpha_blend_unit.sv
// top level of the cursor overlay alpha blend unit
//
// channels: s_* takes one word per request. s_tuser is the request kind: a load
// writes one cursor pixel (already in output orientation) at cursor_addr and
// returns nothing; a composite sends one background pixel with its coordinate
// and returns exactly one word on m_*. cfg_* writes one register per word and is
// always ready; registers must be written only while the unit is empty, which
// the unit itself does not enforce. a background pixel under the placed cursor
// whose cursor alpha is nonzero is blended source-over with rounding and
// m_tuser is set; other pixels pass as is. a composite passes the input
// register, cursor memory read, two multiply stages, an eight-stage restoring
// divider and the output register. one word per clock is taken while m_* is not
// stalled, loads and composites mixed freely. the pipeline advances as one; its
// pace is set by the output register, so a stalled m_tready holds every stage and
// drops s_tready in the same cycle. loads and reads hit the cursor memory from
// the same stage in order, so a composite right after a load sees the new pixel.
// reset clears the valid bits and the registers to their reset values; the
// cursor memory is not cleared and must be loaded before it is shown.
module cursor_overlay_alpha_blend_unit #(
	parameter int MAX_CURSOR_SIDE = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cursor_addr[11:0], pixel_x[24:12], pixel_y[37:25], red[45:38],
	// green[53:46], blue[61:54], alpha[69:62], zero fill
	input  logic [coab_pkg::S_DATA_W-1:0]    s_tdata,
	// req_type
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
	output logic [coab_pkg::M_DATA_W-1:0]    m_tdata,
	// blended
	output logic                             m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [2:0]                       cfg_index,
	input  logic [coab_pkg::CFG_W-1:0]       cfg_data
);

	import coab_pkg::*;

	`include "assert_macros.svh"

	localparam int SIDE_W = $clog2(MAX_CURSOR_SIDE + 1);
	localparam int DEPTH  = MAX_CURSOR_SIDE * MAX_CURSOR_SIDE;
	localparam int AW     = $clog2(DEPTH);

	// configuration registers
	logic signed [13:0] pos_x_q, pos_y_q;
	logic [6:0]         hot_x_q, hot_y_q, src_w_q, src_h_q;
	logic [2:0]         orient_q;
	logic               visible_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			hot_x_q   <= '0;
			hot_y_q   <= '0;
			src_w_q   <= 7'd1;
			src_h_q   <= 7'd1;
			orient_q  <= ORI_NORMAL;
			visible_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data;
				REG_POS_Y:   pos_y_q   <= cfg_data;
				REG_HOT_X:   hot_x_q   <= cfg_data[6:0];
				REG_HOT_Y:   hot_y_q   <= cfg_data[6:0];
				REG_SRC_W:   src_w_q   <= cfg_data[6:0];
				REG_SRC_H:   src_h_q   <= cfg_data[6:0];
				REG_ORIENT:  orient_q  <= cfg_data[2:0];
				REG_VISIBLE: visible_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// placement geometry, refreshed every cycle from the registers
	logic [SIDE_W-1:0]  w_sat, h_sat;
	logic signed [9:0]  w_s, h_s, x_s, y_s, hx, hy;
	logic signed [16:0] left_q, top_q;
	logic [SIDE_W-1:0]  tw_q, th_q;

	always_comb begin
		w_sat = (int'(src_w_q) > MAX_CURSOR_SIDE) ? SIDE_W'(MAX_CURSOR_SIDE) : SIDE_W'(src_w_q);
		h_sat = (int'(src_h_q) > MAX_CURSOR_SIDE) ? SIDE_W'(MAX_CURSOR_SIDE) : SIDE_W'(src_h_q);
		w_s   = signed'(10'(w_sat));
		h_s   = signed'(10'(h_sat));
		x_s   = signed'(10'(hot_x_q));
		y_s   = signed'(10'(hot_y_q));
		hx    = x_s;
		hy    = y_s;
		case (orient_q)
			ORI_R90:  begin hx = h_s - y_s; hy = x_s;       end
			ORI_R180: begin hx = w_s - x_s; hy = h_s - y_s; end
			ORI_R270: begin hx = y_s;       hy = w_s - x_s; end
			ORI_FLIP: begin hx = w_s - x_s;                 end
			ORI_F90:  begin hx = h_s - y_s; hy = w_s - x_s; end
			ORI_F180: begin hy = h_s - y_s;                 end
			ORI_F270: begin hx = y_s;       hy = x_s;       end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		left_q <= 17'(pos_x_q) - 17'(hx);
		top_q  <= 17'(pos_y_q) - 17'(hy);
		tw_q   <= orient_q[0] ? h_sat : w_sat;
		th_q   <= orient_q[0] ? w_sat : h_sat;
	end

	// global advance: everything moves when the output register can take a word
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: registered request
	logic              v_s1, typ_s1;
	logic [11:0]       caddr_s1;
	logic [12:0]       px_s1, py_s1;
	pixel_t            pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			typ_s1   <= s_tuser;
			caddr_s1 <= s_tdata[11:0];
			px_s1    <= s_tdata[24:12];
			py_s1    <= s_tdata[37:25];
			pix_s1   <= s_tdata[69:38];
		end
	end

	// cover test and memory address of the cursor pixel under this coordinate
	logic signed [16:0] dx, dy;
	logic               covered;
	logic [2*SIDE_W-1:0] rel_addr;
	logic               ram_we;
	logic [31:0]        ram_rdata;

	always_comb begin
		dx       = signed'(17'(px_s1)) - left_q;
		dy       = signed'(17'(py_s1)) - top_q;
		covered  = (dx >= 0) && (dx < signed'(17'(tw_q)))
			&& (dy >= 0) && (dy < signed'(17'(th_q)));
		rel_addr = dy[SIDE_W-1:0] * tw_q + (2*SIDE_W)'(dx[SIDE_W-1:0]);
	end

	assign ram_we = en && v_s1 && (typ_s1 == REQ_LOAD) && (17'(caddr_s1) < 17'(DEPTH));

	coab_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_cursor_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(caddr_s1)),
		.wdata (pix_s1),
		.re    (en),
		.raddr (AW'(rel_addr)),
		.rdata (ram_rdata)
	);

	// stage 2: cursor pixel is out of the memory
	logic   v_s2, hit_s2;
	pixel_t pix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && (typ_s1 == REQ_COMP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2 <= visible_q && covered;
			pix_s2 <= pix_s1;
		end
	end

	// products of cursor alpha with its channels, and of background alpha with inverse cursor alpha
	pixel_t     cur;
	logic [7:0] inv_sa;
	assign cur    = ram_rdata;
	assign inv_sa = 8'd255 - cur.a;

	logic        v_s3, blend_s3;
	pixel_t      pix_s3;
	logic [15:0] sa255_s3, rem_s3;
	logic [15:0] psc_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blend_s3  <= hit_s2 && (cur.a != 8'd0);
			pix_s3    <= pix_s2;
			sa255_s3  <= {cur.a, 8'd0} - 16'(cur.a);
			rem_s3    <= pix_s2.a * inv_sa;
			psc_s3[0] <= cur.r * cur.a;
			psc_s3[1] <= cur.g * cur.a;
			psc_s3[2] <= cur.b * cur.a;
		end
	end

	// stage 3: combined weight and rounded numerators
	logic [COMB_W-1:0] comb;
	logic [7:0]        dst [3];
	assign comb   = 17'(sa255_s3) + 17'(rem_s3);
	assign dst[0] = pix_s3.r;
	assign dst[1] = pix_s3.g;
	assign dst[2] = pix_s3.b;

	logic              v_s4, blend_s4;
	pixel_t            pix_s4;
	logic [COMB_W-1:0] comb_s4;
	logic [NUM_W-1:0]  num_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blend_s4 <= blend_s3;
			pix_s4   <= pix_s3;
			comb_s4  <= comb;
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= NUM_W'({psc_s3[i], 8'd0}) - NUM_W'(psc_s3[i])
					+ NUM_W'(dst[i]) * NUM_W'(rem_s3) + NUM_W'(comb[COMB_W-1:1]);
			end
		end
	end

	// stage 4 on: one divider per color channel
	logic [QUO_W-1:0] quo [3];

	for (genvar c = 0; c < 3; c++) begin : g_div
		coab_div #(
			.NW (NUM_W),
			.DW (COMB_W),
			.QW (QUO_W)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s4[c]),
			.den (comb_s4),
			.quo (quo[c])
		);
	end

	// output alpha: (comb + 127) / 255 by reciprocal with one correction
	logic [17:0] ax;
	logic [25:0] ax257;
	logic [9:0]  aq0;
	logic [17:0] ar;
	logic [7:0]  alpha_new;

	always_comb begin
		ax        = 18'(comb_s4) + 18'd127;
		ax257     = 26'(ax) + {ax, 8'd0};
		aq0       = ax257[25:16];
		ar        = ax - ({aq0, 8'd0} - 18'(aq0));
		alpha_new = (ar >= 18'd255) ? 8'(aq0 + 10'd1) : aq0[7:0];
	end

	// side line running alongside the divider stages
	logic   sv_q [QUO_W];
	logic   sblend_q [QUO_W];
	pixel_t spix_q [QUO_W];
	logic [7:0] salpha_q [QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUO_W; k++) begin
				sv_q[k] <= 1'b0;
			end
		end else if (en) begin
			sv_q[0] <= v_s4;
			for (int k = 1; k < QUO_W; k++) begin
				sv_q[k] <= sv_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sblend_q[0] <= blend_s4;
			spix_q[0]   <= pix_s4;
			salpha_q[0] <= alpha_new;
			for (int k = 1; k < QUO_W; k++) begin
				sblend_q[k] <= sblend_q[k-1];
				spix_q[k]   <= spix_q[k-1];
				salpha_q[k] <= salpha_q[k-1];
			end
		end
	end

	// output register
	logic   m_tvalid_q, m_tuser_q;
	pixel_t m_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= sv_q[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser_q <= sblend_q[QUO_W-1];
			if (sblend_q[QUO_W-1]) begin
				m_pix_q <= {salpha_q[QUO_W-1], quo[2], quo[1], quo[0]};
			end else begin
				m_pix_q <= spix_q[QUO_W-1];
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_pix_q;

	// checks
	`COAB_ASSERT_NEXT(a_comp_enters, s_tvalid && s_tready && (s_tuser == REQ_COMP), v_s1 && (typ_s1 == REQ_COMP))
	`COAB_ASSERT_IMPLY(a_blend_visible, m_tvalid && m_tuser, visible_q)
	`COAB_ASSERT_IMPLY(a_blend_alpha, m_tvalid && m_tuser, m_tdata[31:24] != 8'd0)

endmodule

// File: rtl/coab_ram.sv
// generic simple dual-port ram with registered read
module coab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/coab_div.sv
// pipelined restoring divider, one quotient bit per stage
module coab_div #(
	parameter int NW = 25,
	parameter int DW = 17,
	parameter int QW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int XW = NW + QW + 1;

	logic [NW-1:0] rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [XW-1:0] sh;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
		end

		assign sh = XW'(d_in) << (QW - 1 - k);
		assign ge = XW'(r_in) >= sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? (r_in - sh[NW-1:0]) : r_in;
				den_q[k] <= d_in;
				quo_q[k] <= q_in | (QW'(ge) << (QW - 1 - k));
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule
